[rtl/gcr62_pkg.sv]
// shared types, constants and the inverse 6-and-2 lookup for the sector decoder
`timescale 1ns / 1ps
package gcr62_pkg;

  localparam int unsigned GROUP_LEN      = 86;
  localparam int unsigned DATA_LEN       = 256;
  localparam int unsigned SLOT_W         = $clog2(GROUP_LEN);
  localparam int unsigned SIX_W          = 6;
  localparam int unsigned LAST_SLOT      = GROUP_LEN - 1;
  localparam int unsigned LAST_DATA_SLOT = DATA_LEN - 2 * GROUP_LEN - 1;
  localparam int unsigned CMD_DEPTH      = 4;
  localparam int unsigned OUT_DEPTH      = 4;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_DATA,
    CMD_STATUS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        grp;
    logic [SIX_W-1:0]  sum;
    logic              err;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic       checksum_good;
    logic       bad_nibble_seen;
  } result_t;

  localparam logic [7:0] GCR_CODE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // returns {hit, six}; six is zero on a miss
  function automatic logic [SIX_W:0] gcr_decode(input logic [7:0] nib);
    logic [SIX_W:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      if (GCR_CODE[i] == nib) begin
        res = {1'b1, SIX_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

[rtl/gcr62_fifo.sv]
// small register queue used between front and back and on the result side
`timescale 1ns / 1ps
module gcr62_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/gcr62_front.sv]
// front end: nibble lookup, checksum chain, sector position and command build
`timescale 1ns / 1ps
module gcr62_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        nibble_i,
  output gcr62_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    PH_STORE,
    PH_DATA0,
    PH_DATA1,
    PH_DATA2,
    PH_STATUS
  } phase_e;

  phase_e                           phase_q, phase_d;
  logic [gcr62_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [gcr62_pkg::SIX_W-1:0]      sum_q, sum_d;
  logic                             err_q, err_d;
  logic [gcr62_pkg::SIX_W:0]        dec;
  logic [gcr62_pkg::SIX_W-1:0]      sum_new;
  logic                             err_new;
  logic                             slot_last;
  logic                             data2_last;

  assign dec        = gcr62_pkg::gcr_decode(nibble_i);
  assign sum_new    = sum_q ^ dec[gcr62_pkg::SIX_W-1:0];
  assign err_new    = err_q | ~dec[gcr62_pkg::SIX_W];
  assign slot_last  = (slot_q == gcr62_pkg::SLOT_W'(gcr62_pkg::LAST_SLOT));
  assign data2_last = (slot_q == gcr62_pkg::SLOT_W'(gcr62_pkg::LAST_DATA_SLOT));

  always_comb begin
    cmd_o.slot = slot_q;
    cmd_o.sum  = sum_new;
    cmd_o.err  = err_new;
    cmd_o.kind = gcr62_pkg::CMD_DATA;
    cmd_o.grp  = 2'd0;
    phase_d    = phase_q;
    slot_d     = slot_q + 1'b1;
    sum_d      = sum_new;
    err_d      = err_new;
    unique case (phase_q)
      PH_STORE: begin
        cmd_o.kind = gcr62_pkg::CMD_STORE;
        if (slot_last) begin
          phase_d = PH_DATA0;
          slot_d  = '0;
        end
      end
      PH_DATA0: begin
        if (slot_last) begin
          phase_d = PH_DATA1;
          slot_d  = '0;
        end
      end
      PH_DATA1: begin
        cmd_o.grp = 2'd1;
        if (slot_last) begin
          phase_d = PH_DATA2;
          slot_d  = '0;
        end
      end
      PH_DATA2: begin
        cmd_o.grp = 2'd2;
        if (data2_last) begin
          phase_d = PH_STATUS;
          slot_d  = '0;
        end
      end
      PH_STATUS: begin
        // end of sector: chain and sticky flag restart
        cmd_o.kind = gcr62_pkg::CMD_STATUS;
        phase_d    = PH_STORE;
        slot_d     = '0;
        sum_d      = '0;
        err_d      = 1'b0;
      end
      default: begin
        phase_d = PH_STORE;
        slot_d  = '0;
        sum_d   = '0;
        err_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STORE;
      slot_q  <= '0;
      sum_q   <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      err_q   <= err_d;
    end
  end

endmodule

[rtl/gcr62_back.sv]
// back end: low-bit store, registered read and result assembly
`timescale 1ns / 1ps
module gcr62_back #(
  parameter int unsigned OutDepth = gcr62_pkg::OUT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcr62_pkg::cmd_t               cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  input  logic [$clog2(OutDepth+1)-1:0] out_count_i,
  output logic                          out_push_o,
  output gcr62_pkg::result_t            out_data_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1) + 1;

  logic [gcr62_pkg::SIX_W-1:0] store_q [gcr62_pkg::GROUP_LEN];
  logic [gcr62_pkg::SIX_W-1:0] rd_q;
  logic                        s1_valid_q;
  gcr62_pkg::cmd_t             s1_cmd_q;
  logic                        issue;
  logic                        is_store;
  logic [1:0]                  pair;

  // a slot in the result queue is reserved for anything in flight
  assign issue     = ~cmd_empty_i &&
                     ((CntW'(out_count_i) + CntW'(s1_valid_q)) < CntW'(OutDepth));
  assign cmd_pop_o = issue;
  assign is_store  = (cmd_i.kind == gcr62_pkg::CMD_STORE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue & ~is_store;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_cmd_q <= cmd_i;
      if (is_store) begin
        store_q[cmd_i.slot] <= cmd_i.sum;
      end else if (cmd_i.kind == gcr62_pkg::CMD_DATA) begin
        rd_q <= store_q[cmd_i.slot];
      end
    end
  end

  always_comb begin
    unique case (s1_cmd_q.grp)
      2'd0:    pair = rd_q[1:0];
      2'd1:    pair = rd_q[3:2];
      2'd2:    pair = rd_q[5:4];
      default: pair = 2'b00;
    endcase
  end

  assign out_push_o = s1_valid_q;

  always_comb begin
    out_data_o.bad_nibble_seen = s1_cmd_q.err;
    if (s1_cmd_q.kind == gcr62_pkg::CMD_STATUS) begin
      out_data_o.data_byte     = 8'h00;
      out_data_o.is_status     = 1'b1;
      out_data_o.checksum_good = (s1_cmd_q.sum == '0);
    end else begin
      out_data_o.data_byte     = {s1_cmd_q.sum, pair[0], pair[1]};
      out_data_o.is_status     = 1'b0;
      out_data_o.checksum_good = 1'b0;
    end
  end

endmodule

[rtl/gcr_six_two_sector_decoder.sv]
// top level of the 6-and-2 gcr sector decoder
// a data or status result passes the command queue, the back's result register and the result queue
// throughput: one nibble per cycle sustained unless a queue fills; the low-bit store has one write or read a cycle
// a sector is 343 nibbles: 86 give no result, 256 give data bytes, the last gives status
// reset clears position, checksum chain, sticky flag and both queues
// the low-bit store is not cleared; every entry is written before it is read in a sector
`timescale 1ns / 1ps
module gcr_six_two_sector_decoder #(
  parameter int unsigned CmdDepth = gcr62_pkg::CMD_DEPTH,
  parameter int unsigned OutDepth = gcr62_pkg::OUT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input side, queue style
  input  logic       push,
  output logic       full,
  input  logic [7:0] disk_nibble_i,
  // result side, queue style
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       is_status_o,
  output logic       checksum_good_o,
  output logic       bad_nibble_seen_o
);

  localparam int unsigned CmdW = $bits(gcr62_pkg::cmd_t);
  localparam int unsigned ResW = $bits(gcr62_pkg::result_t);

  logic                          accept;
  gcr62_pkg::cmd_t               cmd_wr;
  gcr62_pkg::cmd_t               cmd_rd;
  logic [CmdW-1:0]               cmd_rd_bits;
  logic                          cmd_empty;
  logic                          cmd_pop;
  logic [$clog2(CmdDepth+1)-1:0] cmd_count;
  logic                          out_push;
  logic                          out_full;
  gcr62_pkg::result_t            out_wr;
  gcr62_pkg::result_t            out_rd;
  logic [ResW-1:0]               out_rd_bits;
  logic [$clog2(OutDepth+1)-1:0] out_count;

  // an item is taken whenever the command queue has room
  assign accept = push & ~full;

  // front: lookup, chain and position tracking, one command per nibble
  gcr62_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .nibble_i (disk_nibble_i),
    .cmd_o    (cmd_wr)
  );

  // decoupling queue between front and back
  gcr62_fifo #(
    .Depth (CmdDepth),
    .Width (CmdW)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_wr),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd_bits),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  assign cmd_rd = gcr62_pkg::cmd_t'(cmd_rd_bits);

  // back: store writes, store reads and byte assembly
  gcr62_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_rd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_data_o  (out_wr)
  );

  // result queue keeps the back running while the consumer stalls
  gcr62_fifo #(
    .Depth (OutDepth),
    .Width (ResW)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rd_bits),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_rd            = gcr62_pkg::result_t'(out_rd_bits);
  assign data_byte_o       = out_rd.data_byte;
  assign is_status_o       = out_rd.is_status;
  assign checksum_good_o   = out_rd.checksum_good;
  assign bad_nibble_seen_o = out_rd.bad_nibble_seen;

  // the back never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("result queue overflow");

  // the back only takes commands that are there
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> (cmd_count != '0))
    else $error("command taken from empty queue");

  // a status result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_status_o) |-> (data_byte_o == 8'h00))
    else $error("status result with nonzero byte");

  // checksum flag only appears on a status result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_status_o) |-> !checksum_good_o)
    else $error("checksum flag on data result");

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the six-and-two gcr sector decoder
`timescale 1ns / 1ps
module tb_top;

  // sector layout: 86 store nibbles, 256 data nibbles, then one status nibble
  localparam int GROUP_N    = gcr62_pkg::GROUP_LEN;
  localparam int DATA_N     = gcr62_pkg::DATA_LEN;
  localparam int STATUS_POS = GROUP_N + DATA_N;

  localparam int ITEM_TARGET = 1100;
  localparam int TAIL_CYCLES = 16;      // idle tail after the drain, leave plenty of slack
  localparam int CYCLE_LIMIT = 400000;  // slowest legal run is far below this

  // the 64 valid disk nibbles, index is the decoded 6-bit value
  localparam logic [7:0] DISK_CODE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // directed nibbles: table edges, byte extremes, the mark bytes and other invalid codes
  localparam int DIRECTED_N = 20;
  localparam logic [7:0] DIRECTED_NIB [DIRECTED_N] = '{
    8'h96, 8'hFF, 8'h97, 8'hFE, 8'h00, 8'hFF, 8'h80, 8'h7F,
    8'h95, 8'hAA, 8'hD5, 8'h55, 8'h01, 8'hCB, 8'hCA, 8'hD3,
    8'hE5, 8'hE4, 8'hF9, 8'hF8
  };

  // flavors of generated sectors
  typedef enum logic [1:0] {
    SEC_CLEAN,    // valid nibbles, last one closes the checksum
    SEC_SPOTTY,   // a few invalid nibbles sprinkled in, checksum still closed
    SEC_BAD_SUM,  // valid nibbles, last one leaves the checksum nonzero
    SEC_NOISE     // arbitrary bytes
  } sector_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic       checksum_good;
    logic       bad_nibble_seen;
  } sector_out_t;

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       push              = 1'b0;
  logic [7:0] disk_nibble_i     = 8'h00;
  logic       pop               = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] data_byte_o;
  logic       is_status_o;
  logic       checksum_good_o;
  logic       bad_nibble_seen_o;

  // decoder state mirrored in the testbench
  int unsigned sector_pos;
  logic [5:0]  chain_sum;
  logic [5:0]  low_pairs [GROUP_N];
  logic        bad_seen;

  sector_out_t decoded_q [$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 65;

  gcr_six_two_sector_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .disk_nibble_i    (disk_nibble_i),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .is_status_o      (is_status_o),
    .checksum_good_o  (checksum_good_o),
    .bad_nibble_seen_o(bad_nibble_seen_o)
  );

  always #10 clk_i = ~clk_i;

  // advance the mirrored decoder by one accepted nibble and queue what it produces
  function automatic void decode_nibble(input logic [7:0] nib);
    logic [5:0]  six;
    logic        hit;
    int unsigned k;
    int unsigned grp;
    logic [5:0]  word;
    logic [1:0]  pair;
    sector_out_t res;
    six = '0;
    hit = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (DISK_CODE[i] == nib) begin
        six = i[5:0];
        hit = 1'b1;
      end
    end
    // an invalid nibble adds zero to the chain but marks the sector
    if (!hit) bad_seen = 1'b1;
    chain_sum = chain_sum ^ six;
    if (sector_pos < GROUP_N) begin
      low_pairs[sector_pos] = chain_sum;
      sector_pos++;
    end else if (sector_pos < STATUS_POS) begin
      k    = sector_pos - GROUP_N;
      grp  = k / GROUP_N;
      word = low_pairs[k % GROUP_N];
      pair = 2'(word >> (2 * grp));
      // the two low bits travel swapped in the stored word
      res.data_byte       = {chain_sum, pair[0], pair[1]};
      res.is_status       = 1'b0;
      res.checksum_good   = 1'b0;
      res.bad_nibble_seen = bad_seen;
      decoded_q.push_back(res);
      sector_pos++;
    end else begin
      res.data_byte       = 8'h00;
      res.is_status       = 1'b1;
      res.checksum_good   = (chain_sum == 6'd0);
      res.bad_nibble_seen = bad_seen;
      decoded_q.push_back(res);
      // end of sector: counters restart, the store keeps its contents
      sector_pos = 0;
      chain_sum  = '0;
      bad_seen   = 1'b0;
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_nibble(input logic [7:0] nib);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    disk_nibble_i <= nib;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_nibble(nib);
    @(negedge clk_i);
  endtask

  function automatic sector_kind_e pick_sector_kind(input int unsigned sector_idx);
    int unsigned roll;
    roll = $urandom_range(99);
    // the first fully generated sector is always clean so a good checksum shows up
    if (sector_idx == 1) return SEC_CLEAN;
    if (roll < 40) return SEC_CLEAN;
    if (roll < 65) return SEC_SPOTTY;
    if (roll < 85) return SEC_BAD_SUM;
    return SEC_NOISE;
  endfunction

  // next nibble of a generated sector, based on the mirrored position and chain
  function automatic logic [7:0] gen_nibble(input sector_kind_e kind);
    logic [7:0] nib;
    nib = DISK_CODE[$urandom_range(63)];
    case (kind)
      SEC_CLEAN: begin
        if (sector_pos == STATUS_POS) nib = DISK_CODE[chain_sum];
      end
      SEC_SPOTTY: begin
        if (sector_pos == STATUS_POS) nib = DISK_CODE[chain_sum];
        else if ($urandom_range(99) < 4) nib = 8'($urandom_range(255));
      end
      SEC_BAD_SUM: begin
        if (sector_pos == STATUS_POS) nib = DISK_CODE[chain_sum ^ 6'($urandom_range(1, 63))];
      end
      SEC_NOISE: begin
        nib = 8'($urandom_range(255));
      end
      default: begin
        nib = 8'($urandom_range(255));
      end
    endcase
    return nib;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 'h%02h, got 'h%02h", $time, fname, want, got);
    end
  endtask

  // receiver: pop decided at the falling edge
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker: every popped item is matched against the oldest expectation
  always @(posedge clk_i) begin
    sector_out_t want;
    if (rst_ni && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, got data 'h%02h status %0b good %0b bad %0b",
                 $time, data_byte_o, is_status_o, checksum_good_o, bad_nibble_seen_o);
      end else begin
        want = decoded_q.pop_front();
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("is_status", 8'(want.is_status), 8'(is_status_o));
        check_field("checksum_good", 8'(want.checksum_good), 8'(checksum_good_o));
        check_field("bad_nibble_seen", 8'(want.bad_nibble_seen), 8'(bad_nibble_seen_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, decoded_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned  sent;
    int unsigned  sectors_done;
    bit           new_sector;
    sector_kind_e kind;

    sector_pos   = 0;
    chain_sum    = '0;
    bad_seen     = 1'b0;
    sent         = 0;
    sectors_done = 0;
    new_sector   = 1'b1;
    kind         = SEC_CLEAN;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part: lands in the store region of the first sector, so it only
    // shapes the chain and the sticky flag that later data items report
    for (int r = 0; r < DIRECTED_N; r++) begin
      send_nibble(DIRECTED_NIB[r]);
      sent++;
    end
    // the first random sector finishes what the directed part started
    new_sector = 1'b1;

    // random part, idle pattern changes by thirds
    while (sent < ITEM_TARGET) begin
      if (sent < ITEM_TARGET / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 65;
      end else if (sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (new_sector) kind = pick_sector_kind(sectors_done);
      send_nibble(gen_nibble(kind));
      sent++;
      new_sector = (sector_pos == 0);
      if (new_sector) sectors_done++;
    end
    push <= 1'b0;

    // drain, then give the pipeline time to show anything extra
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[gcr_six_two_sector_decoder.f]
rtl/gcr62_pkg.sv
rtl/gcr62_fifo.sv
rtl/gcr62_front.sv
rtl/gcr62_back.sv
rtl/gcr_six_two_sector_decoder.sv
tb/sv/tb_top.sv
